>>> hdl/sph_pkg.sv
// ----------------------------------------------------------------------------
// sph_pkg
// Shared types, constants and small arithmetic helpers for the string
// position hash block.
// ----------------------------------------------------------------------------
package sph_pkg;

    localparam int unsigned CODE_W    = 7;
    localparam int unsigned TAB_DEPTH = 128;

    localparam logic [CODE_W-1:0] CODE_MASK = 7'h7f;

    localparam logic [5:0] MOD_A = 6'd13;
    localparam logic [5:0] MOD_B = 6'd29;
    localparam logic [5:0] MOD_C = 6'd37;
    localparam logic [5:0] MOD_D = 6'd11;

    localparam logic [2:0] POS5_ZERO = 3'd0;
    localparam logic [2:0] POS5_ONE  = 3'd1;
    localparam logic [2:0] POS5_LAST = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_REM  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    typedef enum logic [5:0] {
        PH_LOAD = 6'b000001,
        PH_LL   = 6'b000010,
        PH_LH   = 6'b000100,
        PH_HL   = 6'b001000,
        PH_SUM  = 6'b010000,
        PH_DONE = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        STEP_CD   = 3'd0,
        STEP_POS  = 3'd1,
        STEP_DIST = 3'd2,
        STEP_M13  = 3'd3,
        STEP_M3   = 3'd4,
        STEP_M7   = 3'd5,
        STEP_M29  = 3'd6,
        STEP_M37  = 3'd7
    } t_step;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_tab_ctl;

    typedef struct packed {
        logic [3:0] r13;
        logic [4:0] r29;
        logic [5:0] r37;
        logic [3:0] r11;
    } t_rems;

    function automatic logic [5:0] rem_nib(input logic [5:0] r, input logic [3:0] nib,
                                           input logic [5:0] m);
        logic [6:0] t;
        logic [5:0] acc;
        acc = r;
        for (int k = 3; k >= 0; k--) begin
            t = {acc, nib[k]};
            if (t >= {1'b0, m}) begin
                t = t - {1'b0, m};
            end
            acc = t[5:0];
        end
        return acc;
    endfunction

    function automatic logic [4:0] div7(input logic [7:0] d);
        logic [15:0] t;
        t = {8'h00, d} * 16'd147;
        return t[14:10];
    endfunction

    function automatic logic [1:0] mod3(input logic [7:0] d);
        logic [15:0] t;
        logic [7:0]  q;
        logic [7:0]  r;
        t = {8'h00, d} * 16'd171;
        q = {1'b0, t[15:9]};
        r = d - (q + q + q);
        return r[1:0];
    endfunction

endpackage

>>> hdl/string_position_hash.sv
// ----------------------------------------------------------------------------
// string_position_hash
// Byte-serial string hash. A small sequencer runs every product of a
// character through one shared 32 x 32 multiplier.
// ----------------------------------------------------------------------------
//  channel  | valid         | stall         | payload
//  input    | i_in_valid    | o_in_stall    | i_ch, i_end_of_string
//  output   | o_out_valid   | i_out_stall   | o_hash
//
//  A hashed byte holds the input stall through one table read, then three
//  64-bit products on the shared multiplier. A byte that brings the position
//  to a multiple of five adds a remainder pass and five more products. A
//  string end then loads the output register, waiting while a previous hash
//  is still stalled there. Reset is synchronous and clears the hash state and
//  every table entry at once; the block then takes input.
// ----------------------------------------------------------------------------
module string_position_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_string,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash
);

    sph_pkg::t_state r_state, n_state;
    sph_pkg::t_phase r_ph, n_ph;
    sph_pkg::t_step  r_step, n_step;

    logic [63:0] r_acc, n_acc;
    logic [63:0] r_pos, n_pos;
    logic [2:0]  r_pos5, n_pos5;
    logic [6:0]  r_prev, n_prev;
    logic [6:0]  r_code, n_code;
    logic [7:0]  r_d, n_d;
    logic        r_last, n_last;
    logic [63:0] r_dist, n_dist;
    logic [63:0] r_x, n_x;
    logic [63:0] r_y, n_y;
    logic [63:0] r_p, n_p;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_hash, n_hash;

    logic [6:0]  w_code;
    logic [6:0]  w_diff;
    logic [7:0]  w_d;
    logic [2:0]  w_pos5;
    logic [63:0] w_acc_sum;
    logic [63:0] w_sel_x;
    logic [63:0] w_sel_y;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_mul_p;
    logic [63:0] w_tab_rd;
    logic        w_rem_start;
    logic        w_rem_done;

    sph_pkg::t_tab_ctl w_tab_ctl;
    sph_pkg::t_rems    w_rems;

    sph_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    sph_tab u_tab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_tab_ctl),
        .i_rd_addr (w_code),
        .i_wr_addr (r_code),
        .i_wr_data (r_pos),
        .o_rd_data (w_tab_rd)
    );

    sph_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rem_start),
        .i_value (w_acc_sum),
        .o_done  (w_rem_done),
        .o_rem   (w_rems)
    );

    assign w_code    = i_ch[6:0] & sph_pkg::CODE_MASK;
    assign w_diff    = (r_prev >= w_code) ? (r_prev - w_code) : (w_code - r_prev);
    assign w_d       = (r_pos == 64'd1) ? 8'd1 : ({1'b0, w_diff} + 8'd1);
    assign w_acc_sum = r_acc + r_p;
    assign w_pos5    = (&r_pos) ? sph_pkg::POS5_ZERO :
                       (r_pos5 == sph_pkg::POS5_LAST) ? sph_pkg::POS5_ZERO :
                       (r_pos5 + 3'd1);

    always_comb begin
        unique case (r_step)
            sph_pkg::STEP_CD: begin
                w_sel_x = {57'h0, r_code};
                w_sel_y = {56'h0, r_d};
            end
            sph_pkg::STEP_POS: begin
                w_sel_x = r_p;
                w_sel_y = r_pos;
            end
            sph_pkg::STEP_DIST: begin
                w_sel_x = r_p;
                w_sel_y = r_dist;
            end
            sph_pkg::STEP_M13: begin
                w_sel_x = {60'h0, w_rems.r13};
                w_sel_y = {56'h0, r_d} + 64'd2;
            end
            sph_pkg::STEP_M3: begin
                w_sel_x = r_p;
                w_sel_y = {62'h0, sph_pkg::mod3(r_d)};
            end
            sph_pkg::STEP_M7: begin
                w_sel_x = r_p;
                w_sel_y = {59'h0, sph_pkg::div7(r_d)};
            end
            sph_pkg::STEP_M29: begin
                w_sel_x = {59'h0, w_rems.r29};
                w_sel_y = {57'h0, r_code};
            end
            sph_pkg::STEP_M37: begin
                w_sel_x = {58'h0, w_rems.r37};
                w_sel_y = {57'h0, r_code};
            end
            default: begin
                w_sel_x = r_p;
                w_sel_y = r_pos;
            end
        endcase
    end

    always_comb begin
        unique case (r_ph)
            sph_pkg::PH_LH: begin
                w_mul_a = r_x[31:0];
                w_mul_b = r_y[63:32];
            end
            sph_pkg::PH_HL: begin
                w_mul_a = r_x[63:32];
                w_mul_b = r_y[31:0];
            end
            default: begin
                w_mul_a = r_x[31:0];
                w_mul_b = r_y[31:0];
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_ph        = r_ph;
        n_step      = r_step;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_pos5      = r_pos5;
        n_prev      = r_prev;
        n_code      = r_code;
        n_d         = r_d;
        n_last      = r_last;
        n_dist      = r_dist;
        n_x         = r_x;
        n_y         = r_y;
        n_p         = r_p;
        n_ovalid    = r_ovalid;
        n_hash      = r_hash;
        w_tab_ctl   = '0;
        w_rem_start = 1'b0;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            sph_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_ch == 8'h00) begin
                        n_state = sph_pkg::S_EMIT;
                    end else begin
                        n_code          = w_code;
                        n_d             = w_d;
                        n_last          = i_end_of_string;
                        w_tab_ctl.rd_en = 1'b1;
                        n_state         = sph_pkg::S_READ;
                    end
                end
            end
            sph_pkg::S_READ: begin
                n_dist          = r_pos - w_tab_rd;
                w_tab_ctl.wr_en = 1'b1;
                n_step          = sph_pkg::STEP_CD;
                n_ph            = sph_pkg::PH_LOAD;
                n_state         = sph_pkg::S_MUL;
            end
            sph_pkg::S_MUL: begin
                unique case (r_ph)
                    sph_pkg::PH_LOAD: begin
                        n_x  = w_sel_x;
                        n_y  = w_sel_y;
                        n_ph = sph_pkg::PH_LL;
                    end
                    sph_pkg::PH_LL: begin
                        n_ph = sph_pkg::PH_LH;
                    end
                    sph_pkg::PH_LH: begin
                        n_p  = w_mul_p;
                        n_ph = sph_pkg::PH_HL;
                    end
                    sph_pkg::PH_HL: begin
                        n_p  = r_p + {w_mul_p[31:0], 32'h0};
                        n_ph = sph_pkg::PH_SUM;
                    end
                    sph_pkg::PH_SUM: begin
                        n_p  = r_p + {w_mul_p[31:0], 32'h0};
                        n_ph = sph_pkg::PH_DONE;
                    end
                    sph_pkg::PH_DONE: begin
                        n_ph = sph_pkg::PH_LOAD;
                        unique case (r_step)
                            sph_pkg::STEP_CD:  n_step = sph_pkg::STEP_POS;
                            sph_pkg::STEP_POS: n_step = sph_pkg::STEP_DIST;
                            sph_pkg::STEP_DIST: begin
                                n_acc  = w_acc_sum;
                                n_prev = r_code;
                                n_pos  = r_pos + 64'd1;
                                n_pos5 = w_pos5;
                                if (w_pos5 == sph_pkg::POS5_ZERO) begin
                                    w_rem_start = 1'b1;
                                    n_state     = sph_pkg::S_REM;
                                end else if (r_last) begin
                                    n_state = sph_pkg::S_EMIT;
                                end else begin
                                    n_state = sph_pkg::S_IDLE;
                                end
                            end
                            sph_pkg::STEP_M13: n_step = sph_pkg::STEP_M3;
                            sph_pkg::STEP_M3:  n_step = sph_pkg::STEP_M7;
                            sph_pkg::STEP_M7: begin
                                n_acc  = w_acc_sum;
                                n_step = sph_pkg::STEP_M29;
                            end
                            sph_pkg::STEP_M29: begin
                                n_acc  = w_acc_sum;
                                n_step = sph_pkg::STEP_M37;
                            end
                            sph_pkg::STEP_M37: begin
                                n_acc   = w_acc_sum;
                                n_state = r_last ? sph_pkg::S_EMIT : sph_pkg::S_IDLE;
                            end
                            default: n_state = sph_pkg::S_IDLE;
                        endcase
                    end
                    default: n_ph = sph_pkg::PH_LOAD;
                endcase
            end
            sph_pkg::S_REM: begin
                if (w_rem_done) begin
                    n_acc   = r_acc + {60'h0, w_rems.r11};
                    n_step  = sph_pkg::STEP_M13;
                    n_ph    = sph_pkg::PH_LOAD;
                    n_state = sph_pkg::S_MUL;
                end
            end
            sph_pkg::S_EMIT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid        = 1'b1;
                    n_hash          = r_acc;
                    n_acc           = 64'h0;
                    n_pos           = 64'd1;
                    n_pos5          = sph_pkg::POS5_ONE;
                    n_prev          = 7'h00;
                    w_tab_ctl.clear = 1'b1;
                    n_state         = sph_pkg::S_IDLE;
                end
            end
            default: n_state = sph_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sph_pkg::S_IDLE;
            r_ph     <= sph_pkg::PH_LOAD;
            r_step   <= sph_pkg::STEP_CD;
            r_acc    <= 64'h0;
            r_pos    <= 64'd1;
            r_pos5   <= sph_pkg::POS5_ONE;
            r_prev   <= 7'h00;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ph     <= n_ph;
            r_step   <= n_step;
            r_acc    <= n_acc;
            r_pos    <= n_pos;
            r_pos5   <= n_pos5;
            r_prev   <= n_prev;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_d    <= n_d;
        r_last <= n_last;
        r_dist <= n_dist;
        r_x    <= n_x;
        r_y    <= n_y;
        r_p    <= n_p;
        r_hash <= n_hash;
    end

    assign o_in_stall  = (r_state != sph_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_hash      = r_hash;

endmodule

>>> hdl/sph_mul.sv
// ----------------------------------------------------------------------------
// sph_mul
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module sph_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'h0, i_a} * {32'h0, i_b};
    end

    assign o_p = r_p;

endmodule

>>> hdl/sph_rem.sv
// ----------------------------------------------------------------------------
// sph_rem
// Remainders of a 64-bit value by 13, 29, 37 and 11, four bits per cycle.
// ----------------------------------------------------------------------------
module sph_rem (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_value,
    output logic          o_done,
    output sph_pkg::t_rems o_rem
);

    logic [63:0] r_val, n_val;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_ra, n_ra;
    logic [5:0]  r_rb, n_rb;
    logic [5:0]  r_rc, n_rc;
    logic [5:0]  r_rd, n_rd;

    always_comb begin
        n_val  = r_val;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_ra   = r_ra;
        n_rb   = r_rb;
        n_rc   = r_rc;
        n_rd   = r_rd;
        if (i_start) begin
            n_val  = i_value;
            n_cnt  = 4'd0;
            n_busy = 1'b1;
            n_ra   = 6'd0;
            n_rb   = 6'd0;
            n_rc   = 6'd0;
            n_rd   = 6'd0;
        end else if (r_busy) begin
            n_val = {r_val[59:0], 4'h0};
            n_ra  = sph_pkg::rem_nib(r_ra, r_val[63:60], sph_pkg::MOD_A);
            n_rb  = sph_pkg::rem_nib(r_rb, r_val[63:60], sph_pkg::MOD_B);
            n_rc  = sph_pkg::rem_nib(r_rc, r_val[63:60], sph_pkg::MOD_C);
            n_rd  = sph_pkg::rem_nib(r_rd, r_val[63:60], sph_pkg::MOD_D);
            n_cnt = r_cnt + 4'd1;
            if (&r_cnt) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_ra  <= n_ra;
        r_rb  <= n_rb;
        r_rc  <= n_rc;
        r_rd  <= n_rd;
    end

    assign o_done    = r_done;
    assign o_rem.r13 = r_ra[3:0];
    assign o_rem.r29 = r_rb[4:0];
    assign o_rem.r37 = r_rc[5:0];
    assign o_rem.r11 = r_rd[3:0];

endmodule

>>> hdl/sph_tab.sv
// ----------------------------------------------------------------------------
// sph_tab
// Last-seen position table: 128 x 64 memory with per-entry valid bits that
// clear together at end of string. Invalid entries read as zero.
// ----------------------------------------------------------------------------
module sph_tab (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sph_pkg::t_tab_ctl           i_ctl,
    input  logic [sph_pkg::CODE_W-1:0]  i_rd_addr,
    input  logic [sph_pkg::CODE_W-1:0]  i_wr_addr,
    input  logic [63:0]                 i_wr_data,
    output logic [63:0]                 o_rd_data
);

    logic [63:0]                   r_mem [sph_pkg::TAB_DEPTH];
    logic [sph_pkg::TAB_DEPTH-1:0] r_valid;
    logic [63:0]                   r_rdata;
    logic                          r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata  <= r_mem[i_rd_addr];
            r_rvalid <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rvalid ? r_rdata : 64'h0;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the string position hash block. A queue of byte
// transfers (directed corner strings, then random strings, broken strings and
// noise) feeds a bursty driver. Each accepted byte runs through a predictor
// of the hash, and every hash leaving the block is compared with the oldest
// predicted value. The receiver stalls on its own pattern, with one long
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned HOLD_START  = 2000;
    localparam int unsigned HOLD_LEN    = 1500;
    localparam int unsigned TAIL_CYCLES = 120;
    localparam int unsigned NUM_ITEMS   = 900;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } t_char_item;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_ch            = 8'h00;
    logic        i_end_of_string = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [63:0] o_hash;

    t_char_item  char_q[$];
    logic [63:0] exp_hash_q[$];

    // predictor state
    logic [63:0] str_acc;
    logic [63:0] str_pos;
    logic [6:0]  str_prev;
    logic [63:0] last_pos[sph_pkg::TAB_DEPTH];

    int unsigned cycle_cnt   = 0;
    int unsigned n_accepted  = 0;
    int unsigned n_items     = 0;
    int unsigned err_count   = 0;
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    int unsigned hold_cnt    = 0;
    logic        in_taken    = 1'b0;
    logic        hold_off    = 1'b0;
    logic [1:0]  stall_mode  = 2'd0;

    string_position_hash u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_ch            (i_ch),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hash          (o_hash)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic push_char(input logic [7:0] ch, input logic eos);
        t_char_item it;
        it.ch  = ch;
        it.eos = eos;
        char_q.push_back(it);
    endtask

    task automatic hash_clear();
        str_acc  = 64'd0;
        str_pos  = 64'd1;
        str_prev = 7'd0;
        for (int k = 0; k < sph_pkg::TAB_DEPTH; k++) begin
            last_pos[k] = 64'd0;
        end
    endtask

    task automatic hash_accept(input logic [7:0] ch, input logic eos);
        logic [63:0] code;
        logic [63:0] prev;
        logic [63:0] diff;
        logic [63:0] span;
        logic [63:0] a;
        if (ch != 8'h00) begin
            code = {57'd0, ch[6:0] & sph_pkg::CODE_MASK};
            prev = {57'd0, str_prev};
            if (str_pos == 64'd1) begin
                diff = 64'd1;
            end else begin
                diff = ((prev >= code) ? prev - code : code - prev) + 64'd1;
            end
            span     = str_pos - last_pos[code[6:0]];
            str_acc  = str_acc + code * str_pos * diff * span;
            str_prev = code[6:0];
            last_pos[code[6:0]] = str_pos;
            str_pos  = str_pos + 64'd1;
            if (str_pos % 64'd5 == 64'd0) begin
                a = str_acc;
                str_acc = a + (a % 64'd13) * (diff + 64'd2) * (diff % 64'd3) * (diff / 64'd7)
                            + (a % 64'd29) * code + (a % 64'd37) * code + (a % 64'd11);
            end
        end
        if (ch == 8'h00 || eos) begin
            exp_hash_q.push_back(str_acc);
            hash_clear();
        end
    endtask

    // input acceptance, prediction and output check
    always @(posedge i_clk) begin : mon
        logic [63:0] exp_hash;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            hash_accept(i_ch, i_end_of_string);
            n_accepted++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_hash_q.size() == 0) begin
                report_mismatch($sformatf("unexpected hash %h", o_hash));
            end else begin
                exp_hash = exp_hash_q.pop_front();
                if (o_hash !== exp_hash) begin
                    report_mismatch($sformatf("hash %h, expected %h", o_hash, exp_hash));
                end
            end
        end
    end

    // input driver: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin : drv
        t_char_item it;
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (char_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                it = char_q.pop_front();
                i_in_valid      <= 1'b1;
                i_ch            <= it.ch;
                i_end_of_string <= it.eos;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && hold_cnt < HOLD_START + HOLD_LEN) begin
            hold_cnt <= hold_cnt + 1;
        end
        hold_off <= (hold_cnt >= HOLD_START) && (hold_cnt < HOLD_START + HOLD_LEN);
    end

    // receiver stall pattern
    always @(negedge i_clk) begin : rx
        logic s;
        if ($urandom_range(0, 63) == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        case (stall_mode)
            2'd0: s = 1'b0;
            2'd1: s = ($urandom_range(0, 9) < 3);
            2'd2: s = ~i_out_stall;
            default: s = ($urandom_range(0, 9) < 7);
        endcase
        i_out_stall <= s || hold_off;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("string_position_hash test failed");
            $finish;
        end
    end

    initial begin : main
        int unsigned sel;
        int unsigned len;
        logic [7:0]  ch;
        hash_clear();

        // empty strings, with and without the end flag on the zero byte
        push_char(8'h00, 1'b0);
        push_char(8'h00, 1'b1);
        // single character and a code-zero byte, both ended by the flag
        push_char(8'h41, 1'b1);
        push_char(8'h80, 1'b1);
        // field extremes, ended by a zero byte after a mix
        push_char(8'h80, 1'b0);
        push_char(8'hff, 1'b0);
        push_char(8'h7f, 1'b0);
        push_char(8'h01, 1'b0);
        push_char(8'h00, 1'b0);
        // repeats of one code, aliased through the top bit
        push_char(8'h61, 1'b0);
        push_char(8'h61, 1'b0);
        push_char(8'he1, 1'b0);
        push_char(8'h61, 1'b0);
        push_char(8'h61, 1'b1);
        // widest code swings across two mixes
        for (int k = 0; k < 9; k++) begin
            push_char((k % 2 == 0) ? 8'h01 : 8'h7f, k == 8);
        end

        while (char_q.size() < NUM_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    ch = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                    push_char(ch, 1'($urandom_range(0, 1)));
                end
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        ch = 8'($urandom_range(0, 1) * 128 + 64 + $urandom_range(0, 3));
                    end else begin
                        ch = 8'($urandom_range(1, 255));
                    end
                    // leave the string open when sel is 1
                    push_char(ch, (sel >= 6) && (k == len - 1));
                end
                if (sel >= 2 && sel < 6) begin
                    push_char(8'h00, 1'($urandom_range(0, 1)));
                end
            end
        end
        n_items = char_q.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items) @(posedge i_clk);
        while (exp_hash_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("string_position_hash test passed");
        end else begin
            $display("string_position_hash test failed");
        end
        $finish;
    end

endmodule
